### hw/rtl/utf8_byte_to_codepoint_core_defines.svh
// ----------------------------------------------------------------------------
// utf8_byte_to_codepoint_core_defines
// assertion macros used by the utf-8 decoder core
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_TO_CODEPOINT_CORE_DEFINES_SVH
`define UTF8_BYTE_TO_CODEPOINT_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define U8CP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define U8CP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/u8cp_pkg.sv
// ----------------------------------------------------------------------------
// u8cp_pkg
// word types and byte-class constants of the utf-8 decoder
// ----------------------------------------------------------------------------
package u8cp_pkg;

  localparam int unsigned CP_W = 21;

  // byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD2_BITS  = 8'h1F;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD3_BITS  = 8'h0F;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_CODE  = 8'hF0;
  localparam logic [7:0] LEAD4_BITS  = 8'h07;
  localparam logic [7:0] CONT_BITS   = 8'h3F;

  // continuation bytes still expected
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       string_end;
  } in_word_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            point_valid;
    logic            end_of_string;
  } out_word_t;

endpackage

### hw/rtl/utf8_byte_to_codepoint_core.sv
// ----------------------------------------------------------------------------
// utf8_byte_to_codepoint_core
// utf-8 byte stream to code point decoder, one byte per unstalled cycle
// ----------------------------------------------------------------------------
// Takes one byte word per cycle while in_stall is low and returns at most one
// code point word per byte. A byte below 0x80 seen outside a sequence comes
// out on its own; a 2-, 3- or 4-byte lead opens a sequence and the code point
// comes out with its last continuation byte. Continuation bytes are not
// checked, and overlong and surrogate forms pass through. Stray continuations
// and 0xF8..0xFF leads are dropped. The byte flagged string_end always yields
// a word with end_of_string set (point_valid low and code_point zero when no
// character completes on it), and any sequence left open is discarded. The
// decode is a single pass from the pending-count/partial-point state registers
// into the result register, so a byte can be accepted every cycle unless
// in_stall is high. The result register drains while it loads, so in_stall
// only rises while a result sits in it and out_stall is high.
// ----------------------------------------------------------------------------
`include "utf8_byte_to_codepoint_core_defines.svh"

module utf8_byte_to_codepoint_core
  import u8cp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // decoder state
  logic [1:0]      pend_r, pend_nxt;
  logic [CP_W-1:0] part_r, part_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  logic            acc;
  logic            done;
  logic [CP_W-1:0] cp;
  logic [7:0]      b;
  logic [CP_W-1:0] shifted;

  // the result register frees up when it is empty or being taken
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign b        = in_data.byte_in;
  assign shifted  = {part_r[CP_W-7:0], 6'(b & CONT_BITS)};

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    done     = 1'b0;
    cp       = '0;

    if (pend_r == PEND_NONE) begin
      // lead byte expected
      if (b < ASCII_LIMIT) begin
        cp   = CP_W'(b);
        done = 1'b1;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        part_nxt = CP_W'(b & LEAD2_BITS);
        pend_nxt = PEND_ONE;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        part_nxt = CP_W'(b & LEAD3_BITS);
        pend_nxt = PEND_TWO;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        part_nxt = CP_W'(b & LEAD4_BITS);
        pend_nxt = PEND_THREE;
      end
      // anything else is skipped
    end else begin
      // continuation, taken blind
      part_nxt = shifted;
      pend_nxt = pend_r - 2'd1;
      if (pend_r == PEND_ONE) begin
        cp   = shifted;
        done = 1'b1;
      end
    end

    // end of string closes any open sequence
    if (in_data.string_end) begin
      pend_nxt = PEND_NONE;
      part_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (acc) begin
      out_valid_nxt = done || in_data.string_end;
      if (done || in_data.string_end) begin
        out_data_nxt.code_point    = cp;
        out_data_nxt.point_valid   = done;
        out_data_nxt.end_of_string = in_data.string_end;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= PEND_NONE;
      part_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        pend_r <= pend_nxt;
        part_r <= part_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a word without a character must be the end-of-string marker
  `U8CP_ASSERT_NOW(a_empty_word_is_end, out_valid_r && !out_data_r.point_valid,
    out_data_r.end_of_string && (out_data_r.code_point == '0), "empty word not at end")

  // the end byte leaves the decoder with no open sequence
  `U8CP_ASSERT_NEXT(a_end_clears_state, acc && in_data.string_end,
    (pend_r == PEND_NONE) && (part_r == '0), "state not cleared at end of string")

  // an ascii byte outside a sequence gives a character on the next cycle
  `U8CP_ASSERT_NEXT(a_ascii_emits,
    acc && (pend_r == PEND_NONE) && (in_data.byte_in < ASCII_LIMIT),
    out_valid_r && out_data_r.point_valid
      && (out_data_r.code_point == CP_W'($past(in_data.byte_in))), "ascii byte not emitted")

  // a lead byte alone never produces a character
  `U8CP_ASSERT_NEXT(a_lead_no_emit,
    acc && (pend_r == PEND_NONE) && (in_data.byte_in >= ASCII_LIMIT),
    !(out_valid_r && out_data_r.point_valid), "character emitted on a lead byte")

endmodule
